@@ sv/grtb_pkg.sv @@
// ---------------------------------------------------------------------------
// grtb_pkg
// shared constants, types and arithmetic helpers of the gradient ramp builder
// ---------------------------------------------------------------------------
package grtb_pkg;

  localparam int unsigned TexelsDefault   = 256;
  localparam int unsigned MaxStopsDefault = 16;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned PosW            = 17;
  localparam logic [16:0] PosOne          = 17'h10000;

  // one stored stop: position and straight colour
  typedef struct packed {
    logic [16:0] pos;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
  } stop_t;

  typedef enum logic [3:0] {
    BkIdle,
    BkClear,
    BkRdA,
    BkRdAWait,
    BkSpanSetup,
    BkDivide,
    BkPaint,
    BkEnds,
    BkEndsWait,
    BkEmitRd,
    BkEmitWait,
    BkEmit
  } back_state_e;

  // x * a / 255 rounded to nearest
  function automatic logic [7:0] premul(input logic [7:0] x, input logic [7:0] a);
    logic [15:0] t;
    logic [16:0] s;
    t = x * a;
    s = {1'b0, t} + {9'd0, t[15:8]} + 17'd128;
    return s[15:8];
  endfunction

  function automatic logic [31:0] premul_pack(input stop_t st);
    return {st.alpha, premul(st.blue, st.alpha), premul(st.green, st.alpha),
            premul(st.red, st.alpha)};
  endfunction

endpackage

@@ sv/grtb_ram.sv @@
// ---------------------------------------------------------------------------
// grtb_ram
// generic single-port-write, single-port-read ram with registered read
// ---------------------------------------------------------------------------
module grtb_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

@@ sv/grtb_front.sv @@
// ---------------------------------------------------------------------------
// grtb_front
// accepts stops, saturates position, queues them towards the builder
// ---------------------------------------------------------------------------
module grtb_front import grtb_pkg::*; #(
  parameter int unsigned QDepth = QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [16:0] stop_position_i,
  input  logic [7:0]  stop_red_i,
  input  logic [7:0]  stop_green_i,
  input  logic [7:0]  stop_blue_i,
  input  logic [7:0]  stop_alpha_i,
  input  logic        last_stop_i,
  output logic        q_valid_o,
  output stop_t       q_data_o,
  input  logic        q_pop_i
);
  localparam int unsigned AW = $clog2(QDepth);

  stop_t           buf_q [QDepth];
  logic [AW-1:0]   wp_q, rp_q;
  logic [AW:0]     cnt_q;
  stop_t           in_st;
  logic            do_push, do_pop;

  always_comb begin
    in_st.pos   = (stop_position_i > PosOne) ? PosOne : stop_position_i;
    in_st.red   = stop_red_i;
    in_st.green = stop_green_i;
    in_st.blue  = stop_blue_i;
    in_st.alpha = stop_alpha_i;
    in_st.last  = last_stop_i;
  end

  assign full_o    = (cnt_q == (AW+1)'(QDepth));
  assign q_valid_o = (cnt_q != '0);
  assign q_data_o  = buf_q[rp_q];
  assign do_push   = push_i && !full_o;
  assign do_pop    = q_pop_i && q_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wp_q] <= in_st;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= wp_q + 1'b1;
      if (do_pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end
  end
endmodule

@@ sv/grtb_back.sv @@
// ---------------------------------------------------------------------------
// grtb_back
// stores stops, paints the ramp with a serial divider, emits texel groups
// ---------------------------------------------------------------------------
module grtb_back import grtb_pkg::*; #(
  parameter int unsigned Texels   = TexelsDefault,
  parameter int unsigned MaxStops = MaxStopsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         q_valid_i,
  input  stop_t        q_data_i,
  output logic         q_pop_o,
  output logic         empty_o,
  input  logic         pop_i,
  output logic [7:0]   first_texel_index_o,
  output logic [31:0]  texel_word_a_o,
  output logic [31:0]  texel_word_b_o,
  output logic [31:0]  texel_word_c_o,
  output logic [31:0]  texel_word_d_o,
  output logic         last_group_o
);
  localparam int unsigned SW     = $clog2(MaxStops);
  localparam int unsigned CW     = $clog2(MaxStops + 1);
  localparam int unsigned TW     = $clog2(Texels);
  localparam int unsigned XW     = $clog2(Texels + 1);
  localparam int unsigned Groups = (Texels + 3) / 4;
  localparam int unsigned GW     = (Groups > 1) ? $clog2(Groups) : 1;
  localparam int unsigned BW     = $clog2(Groups * 4);
  localparam int unsigned NW     = XW + 9; // |i*(c2-c1)| < Texels*256
  localparam int unsigned QW     = XW + 9;
  localparam int unsigned BitW   = $clog2(QW + 1);
  localparam int unsigned StW    = $bits(stop_t);

  back_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [SW-1:0] k_q, k_d;
  logic [TW-1:0] t_q, t_d;       // texel counter for clear
  logic [XW-1:0] s_q, s_d, d_q, d_d, i_q, i_d;
  logic [31:0]   c1_q, c1_d, c2_q, c2_d;
  logic [GW-1:0] g_q, g_d;
  logic [1:0]    lane_q, lane_d;
  logic [31:0]   words_q [4];
  logic [31:0]   words_d [4];
  logic          oval_q, oval_d;
  logic [7:0]    oidx_q, oidx_d;
  logic          olast_q, olast_d;
  stop_t         prev_q, prev_d;

  // serial divider over four channels, one quotient bit per cycle
  logic [1:0]    ch_q, ch_d;
  logic [QW-1:0] rem_q, rem_d, quo_q, quo_d;
  logic [NW-1:0] num_q, num_d;
  logic [BitW-1:0] bit_q, bit_d;
  logic          neg_q, neg_d;
  logic [7:0]    res_q [4];
  logic [7:0]    res_d [4];

  // stop store
  logic          s_we;
  logic [SW-1:0] s_waddr, s_raddr;
  logic [StW-1:0] s_rdata;
  stop_t         s_rd;

  grtb_ram #(.Width(StW), .Depth(MaxStops)) u_stop_ram (
    .clk_i  (clk_i),
    .we_i   (s_we),
    .waddr_i(s_waddr),
    .wdata_i(q_data_i),
    .raddr_i(s_raddr),
    .rdata_o(s_rdata)
  );
  assign s_rd = stop_t'(s_rdata);

  // ramp store
  logic          r_we;
  logic [TW-1:0] r_waddr, r_raddr;
  logic [31:0]   r_wdata, r_rdata;

  grtb_ram #(.Width(32), .Depth(Texels)) u_ramp_ram (
    .clk_i  (clk_i),
    .we_i   (r_we),
    .waddr_i(r_waddr),
    .wdata_i(r_wdata),
    .raddr_i(r_raddr),
    .rdata_o(r_rdata)
  );

  // floor(p * Texels / 65536)
  function automatic logic [XW-1:0] tstart(input logic [16:0] p);
    logic [16+XW:0] m;
    m = {{XW{1'b0}}, p} * (17+XW)'(Texels);
    return m[16 +: XW];
  endfunction

  logic [7:0]  ca, cb;
  logic signed [9:0] diff;
  logic [NW-1:0] prod;
  logic [QW:0] trial;
  logic [XW-1:0] e_cur;
  logic [BW-1:0] emit_idx;

  always_comb begin
    ca   = c1_q[8*ch_q +: 8];
    cb   = c2_q[8*ch_q +: 8];
    diff = $signed({2'b0, cb}) - $signed({2'b0, ca});
    prod = NW'(i_q) * NW'(diff[9] ? -diff : diff);
    trial = {rem_q, num_q[NW-1]} - (QW+1)'(d_q);
    e_cur = tstart(s_rd.pos);
    emit_idx = {g_q, lane_q};
  end

  always_comb begin
    state_d = state_q;
    count_d = count_q; k_d = k_q; t_d = t_q; s_d = s_q; d_d = d_q; i_d = i_q;
    c1_d = c1_q; c2_d = c2_q; g_d = g_q; lane_d = lane_q;
    oval_d = oval_q; oidx_d = oidx_q; olast_d = olast_q; prev_d = prev_q;
    ch_d = ch_q; rem_d = rem_q; quo_d = quo_q; num_d = num_q; bit_d = bit_q;
    neg_d = neg_q;
    for (int n = 0; n < 4; n++) begin
      words_d[n] = words_q[n];
      res_d[n]   = res_q[n];
    end
    q_pop_o = 1'b0;
    s_we = 1'b0; s_waddr = count_q[SW-1:0]; s_raddr = k_q;
    r_we = 1'b0; r_waddr = t_q; r_wdata = '0; r_raddr = t_q;

    if (oval_q && pop_i) oval_d = 1'b0;

    case (state_q)
      BkIdle: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          if (count_q < CW'(MaxStops)) begin
            s_we    = 1'b1;
            count_d = count_q + 1'b1;
          end
          if (q_data_i.last) begin
            t_d = '0;
            state_d = BkClear;
          end
        end
      end
      BkClear: begin
        r_we = 1'b1;
        t_d  = t_q + 1'b1;
        if (t_q == TW'(Texels - 1)) begin
          k_d = '0;
          state_d = BkRdA;
        end
      end
      BkRdA: begin
        state_d = BkRdAWait; // read of stop k issued
      end
      BkRdAWait: begin
        prev_d = s_rd;
        if (32'(k_q) + 1 < 32'(count_q)) begin
          k_d = k_q + 1'b1;
          s_raddr = k_q + 1'b1;
          state_d = BkSpanSetup;
        end else begin
          k_d = '0;
          state_d = BkEnds;
        end
      end
      BkSpanSetup: begin
        // s_rd now holds stop k (next), prev_q holds stop k-1
        if (e_cur > tstart(prev_q.pos)) begin
          s_d  = tstart(prev_q.pos);
          d_d  = e_cur - tstart(prev_q.pos);
          c1_d = premul_pack(prev_q);
          c2_d = premul_pack(s_rd);
          i_d  = '0;
          ch_d = '0;
          bit_d = '0;
          state_d = BkDivide;
          num_d = '0; // loaded on the first divide step
          rem_d = '0;
          quo_d = '0;
          neg_d = 1'b0;
        end else begin
          state_d = BkRdAWait;
        end
        prev_d = s_rd;
        // keep the stop for the next pair
        if (!(e_cur > tstart(prev_q.pos))) begin
          if (32'(k_q) + 1 < 32'(count_q)) begin
            k_d = k_q + 1'b1;
            s_raddr = k_q + 1'b1;
            state_d = BkSpanSetup;
          end else begin
            k_d = '0;
            state_d = BkEnds;
          end
        end
      end
      BkDivide: begin
        if (bit_q == '0) begin
          num_d = prod;
          neg_d = diff[9];
          rem_d = '0;
          quo_d = '0;
          bit_d = BitW'(1);
        end else if (bit_q <= BitW'(NW)) begin
          if (!trial[QW]) begin
            rem_d = trial[QW-1:0];
            quo_d = {quo_q[QW-2:0], 1'b1};
          end else begin
            rem_d = {rem_q[QW-2:0], num_q[NW-1]};
            quo_d = {quo_q[QW-2:0], 1'b0};
          end
          num_d = {num_q[NW-2:0], 1'b0};
          bit_d = bit_q + 1'b1;
        end else begin
          // floor of negative: -(q + (rem != 0))
          if (neg_q) begin
            res_d[ch_q] = ca - quo_q[7:0] - 8'(rem_q != '0);
          end else begin
            res_d[ch_q] = ca + quo_q[7:0];
          end
          bit_d = '0;
          ch_d  = ch_q + 1'b1;
          if (ch_q == 2'd3) state_d = BkPaint;
        end
      end
      BkPaint: begin
        r_we    = ((32'(s_q) + 32'(i_q)) < Texels);
        r_waddr = TW'(s_q + i_q);
        r_wdata = {res_q[3], res_q[2], res_q[1], res_q[0]};
        if (i_q + 1'b1 == d_q) begin
          if (32'(k_q) + 1 < 32'(count_q)) begin
            k_d = k_q + 1'b1;
            s_raddr = k_q + 1'b1;
            state_d = BkSpanSetup;
          end else begin
            k_d = '0;
            state_d = BkEnds;
          end
        end else begin
          i_d = i_q + 1'b1;
          ch_d = '0;
          state_d = BkDivide;
        end
      end
      BkEnds: begin
        // prev_q holds the last stop; read stop 0
        s_raddr = '0;
        state_d = BkEndsWait;
      end
      BkEndsWait: begin
        s_raddr = '0;
        r_we    = 1'b1;
        r_waddr = '0;
        r_wdata = premul_pack(s_rd);
        if (lane_q == 2'd0) begin
          lane_d = 2'd1;
        end else begin
          r_waddr = TW'(Texels - 1);
          r_wdata = premul_pack(prev_q);
          lane_d  = '0;
          g_d     = '0;
          state_d = BkEmitRd;
        end
      end
      BkEmitRd: begin
        // output words are refilled only once the previous group has gone
        r_raddr = TW'(emit_idx);
        if (!oval_q || pop_i) begin
          state_d = BkEmitWait;
        end
      end
      BkEmitWait: begin
        words_d[lane_q] = (32'(emit_idx) < Texels) ? r_rdata : '0;
        if (lane_q == 2'd3) begin
          lane_d  = '0;
          state_d = BkEmit;
        end else begin
          lane_d  = lane_q + 1'b1;
          r_raddr = TW'(emit_idx + 1'b1);
          state_d = BkEmitWait;
        end
      end
      BkEmit: begin
        if (!oval_q || pop_i) begin
          oval_d  = 1'b1;
          oidx_d  = 8'({g_q, 2'b00});
          olast_d = (32'(g_q) == Groups - 1);
          if (32'(g_q) == Groups - 1) begin
            count_d = '0;
            state_d = BkIdle;
          end else begin
            g_d = g_q + 1'b1;
            state_d = BkEmitRd;
          end
        end
      end
      default: state_d = BkIdle;
    endcase
  end

  // emit wait reads at the issued address; issue first lane in BkEmitRd
  always_ff @(posedge clk_i) begin
    t_q <= t_d; s_q <= s_d; d_q <= d_d; i_q <= i_d;
    c1_q <= c1_d; c2_q <= c2_d; prev_q <= prev_d;
    rem_q <= rem_d; quo_q <= quo_d; num_q <= num_d; neg_q <= neg_d;
    oidx_q <= oidx_d; olast_q <= olast_d;
    for (int n = 0; n < 4; n++) begin
      words_q[n] <= words_d[n];
      res_q[n]   <= res_d[n];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BkIdle;
      count_q <= '0;
      k_q     <= '0;
      g_q     <= '0;
      lane_q  <= '0;
      ch_q    <= '0;
      bit_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      k_q     <= k_d;
      g_q     <= g_d;
      lane_q  <= lane_d;
      ch_q    <= ch_d;
      bit_q   <= bit_d;
      oval_q  <= oval_d;
    end
  end

  assign empty_o             = !oval_q;
  assign first_texel_index_o = oidx_q;
  assign texel_word_a_o      = words_q[0];
  assign texel_word_b_o      = words_q[1];
  assign texel_word_c_o      = words_q[2];
  assign texel_word_d_o      = words_q[3];
  assign last_group_o        = olast_q;
endmodule

@@ sv/gradient_ramp_texture_builder.sv @@
// ---------------------------------------------------------------------------
// gradient_ramp_texture_builder
// sequence: an ordinary stop goes through the queue into the stop store;
// after the last stop the build clears the ramp, reads the first stop,
// sets up each stop pair, paints each texel with four serial divides and
// a write, writes both end texels, then emits the groups, waiting on pop
// throughput: one gradient at a time, set by the serial span divider
// reset: asynchronous, active low; stop count cleared, no results pending
// ---------------------------------------------------------------------------
module gradient_ramp_texture_builder import grtb_pkg::*; #(
  parameter int unsigned Texels   = TexelsDefault,
  parameter int unsigned MaxStops = MaxStopsDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push,
  output logic         full,
  input  logic [16:0]  stop_position_i,
  input  logic [7:0]   stop_red_i,
  input  logic [7:0]   stop_green_i,
  input  logic [7:0]   stop_blue_i,
  input  logic [7:0]   stop_alpha_i,
  input  logic         last_stop_i,
  output logic         empty,
  input  logic         pop,
  output logic [7:0]   first_texel_index_o,
  output logic [31:0]  texel_word_a_o,
  output logic [31:0]  texel_word_b_o,
  output logic [31:0]  texel_word_c_o,
  output logic [31:0]  texel_word_d_o,
  output logic         last_group_o
);
  // short queue between the saturating front and the builder back
  logic  q_valid, q_pop;
  stop_t q_data;

  grtb_front #(.QDepth(QueueDepth)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .full_o         (full),
    .stop_position_i(stop_position_i),
    .stop_red_i     (stop_red_i),
    .stop_green_i   (stop_green_i),
    .stop_blue_i    (stop_blue_i),
    .stop_alpha_i   (stop_alpha_i),
    .last_stop_i    (last_stop_i),
    .q_valid_o      (q_valid),
    .q_data_o       (q_data),
    .q_pop_i        (q_pop)
  );

  // builder: stop store, ramp clear, span paint, group transfer
  grtb_back #(.Texels(Texels), .MaxStops(MaxStops)) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_valid_i          (q_valid),
    .q_data_i           (q_data),
    .q_pop_o            (q_pop),
    .empty_o            (empty),
    .pop_i              (pop),
    .first_texel_index_o(first_texel_index_o),
    .texel_word_a_o     (texel_word_a_o),
    .texel_word_b_o     (texel_word_b_o),
    .texel_word_c_o     (texel_word_c_o),
    .texel_word_d_o     (texel_word_d_o),
    .last_group_o       (last_group_o)
  );
endmodule

@@ sv/grtb_checker.sv @@
// ---------------------------------------------------------------------------
// grtb_checker
// port-level checks on the result side of the ramp builder
// ---------------------------------------------------------------------------
module grtb_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  first_texel_index_o,
  input logic        last_group_o
);
  // a waiting result stays until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(first_texel_index_o)))
    else $error("result dropped before transfer");

  // groups start on multiples of four
  a_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (first_texel_index_o[1:0] == 2'b00))
    else $error("misaligned group index");

  // after a last group the next group restarts at zero
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && last_group_o) |=> (empty || first_texel_index_o == 8'd0))
    else $error("ramp did not restart at zero");
endmodule

bind gradient_ramp_texture_builder grtb_checker u_grtb_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .empty              (empty),
  .pop                (pop),
  .first_texel_index_o(first_texel_index_o),
  .last_group_o       (last_group_o)
);

@@ tb/tb_gradient_ramp_texture_builder.sv @@
// ---------------------------------------------------------------------------
// tb_gradient_ramp_texture_builder
// loads sorted and unsorted gradient stops, predicts the premultiplied
// texel ramp and compares every four-texel group, under several sender
// and receiver idling phases
// ---------------------------------------------------------------------------
module tb_gradient_ramp_texture_builder;
  import grtb_pkg::*;

  localparam int NTex   = 256;
  localparam int NStops = 16;
  localparam int NGroup = NTex / 4;

  typedef struct {
    logic [16:0] pos;
    logic [7:0]  r, g, b, a;
    logic        last;
  } stop_item_t;

  typedef struct {
    logic [7:0]  idx;
    logic [31:0] w [4];
    logic        last;
  } texel_group_t;

  logic clk_i, rst_ni;
  logic push, full, empty, pop;
  logic [16:0] stop_position_i;
  logic [7:0]  stop_red_i, stop_green_i, stop_blue_i, stop_alpha_i;
  logic        last_stop_i;
  logic [7:0]  first_texel_index_o;
  logic [31:0] texel_word_a_o, texel_word_b_o, texel_word_c_o, texel_word_d_o;
  logic        last_group_o;

  gradient_ramp_texture_builder dut (.*);

  stop_item_t   pending_stops [$];
  texel_group_t expected_groups [$];

  // predictor state
  stop_item_t   held_stops [NStops];
  int           held_count;
  logic [31:0]  ramp [NTex];

  int  errors;
  int  cycle_count;
  int  send_idle_pct, recv_stall_pct;
  bit  stim_done;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // ---- prediction ---------------------------------------------------------
  function automatic logic [7:0] mul_alpha(logic [7:0] x, logic [7:0] a);
    int t;
    t = x * a;
    return 8'((t + (t >> 8) + 128) >> 8);
  endfunction

  function automatic void premul_channels(stop_item_t st, output int ch[4]);
    ch[0] = mul_alpha(st.r, st.a);
    ch[1] = mul_alpha(st.g, st.a);
    ch[2] = mul_alpha(st.b, st.a);
    ch[3] = st.a;
  endfunction

  function automatic logic [31:0] pack_channels(int ch[4]);
    return {ch[3][7:0], ch[2][7:0], ch[1][7:0], ch[0][7:0]};
  endfunction

  // floor division toward minus infinity
  function automatic int div_floor(int n, int d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic void paint_ramp_span(stop_item_t p, stop_item_t q);
    int s, e, d, c1[4], c2[4], v[4];
    s = (int'(p.pos) * NTex) / 65536;
    e = (int'(q.pos) * NTex) / 65536;
    d = e - s;
    if (d < 1) return;
    premul_channels(p, c1);
    premul_channels(q, c2);
    for (int i = 0; i < d; i++) begin
      if (s + i >= NTex) continue;
      for (int k = 0; k < 4; k++)
        v[k] = (c1[k] + div_floor(i * (c2[k] - c1[k]), d)) & 255;
      ramp[s + i] = pack_channels(v);
    end
  endfunction

  function automatic void predict_stop(stop_item_t it);
    int ch[4];
    texel_group_t grp;
    if (it.pos > 17'h10000) it.pos = 17'h10000;
    if (held_count < NStops) begin
      held_stops[held_count] = it;
      held_count++;
    end
    if (!it.last) return;
    foreach (ramp[i]) ramp[i] = '0;
    for (int k = 0; k + 1 < held_count; k++)
      paint_ramp_span(held_stops[k], held_stops[k + 1]);
    premul_channels(held_stops[0], ch);
    ramp[0] = pack_channels(ch);
    premul_channels(held_stops[held_count - 1], ch);
    ramp[NTex - 1] = pack_channels(ch);
    for (int g = 0; g < NGroup; g++) begin
      grp.idx  = 8'(g * 4);
      for (int j = 0; j < 4; j++) grp.w[j] = ramp[g * 4 + j];
      grp.last = (g == NGroup - 1);
      expected_groups.push_back(grp);
    end
    held_count = 0;
  endfunction

  // ---- stimulus helpers ---------------------------------------------------
  function automatic stop_item_t make_stop(int pos, bit last);
    stop_item_t it;
    it.pos = 17'(pos);
    it.r = 8'($urandom); it.g = 8'($urandom); it.b = 8'($urandom); it.a = 8'($urandom);
    it.last = last;
    return it;
  endfunction

  // well-formed gradient of n sorted stops with random content
  task automatic queue_gradient(int n);
    int p;
    p = $urandom_range(0, 20000);
    for (int k = 0; k < n; k++) begin
      pending_stops.push_back(make_stop(p, k == n - 1));
      p = p + $urandom_range(0, 131072 / n);
    end
  endtask

  // ---- driver: a transfer happens when push is high and full is low ------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if ((!push || !full) && pending_stops.size() > 0 &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        stop_item_t it;
        it = pending_stops.pop_front();
        predict_stop(it);
        push            <= 1'b1;
        stop_position_i <= it.pos;
        stop_red_i      <= it.r;
        stop_green_i    <= it.g;
        stop_blue_i     <= it.b;
        stop_alpha_i    <= it.a;
        last_stop_i     <= it.last;
      end else if (push && !full) begin
        push <= 1'b0;
      end
    end
  end

  // ---- monitor: a result transfer happens when pop is high, empty low -----
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if (pop && !empty) begin
        texel_group_t exp_g;
        logic [31:0] got [4];
        got = '{texel_word_a_o, texel_word_b_o, texel_word_c_o, texel_word_d_o};
        if (expected_groups.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected group at texel %0d", first_texel_index_o);
        end else begin
          bit bad;
          exp_g = expected_groups.pop_front();
          bad = (exp_g.idx !== first_texel_index_o) || (exp_g.last !== last_group_o);
          for (int j = 0; j < 4; j++) if (exp_g.w[j] !== got[j]) bad = 1;
          if (bad) begin
            errors++;
            if (errors <= 10)
              $display({"group mismatch: exp idx %0d %h %h %h %h last %0d,",
                        " got idx %0d %h %h %h %h last %0d"},
                       exp_g.idx, exp_g.w[0], exp_g.w[1], exp_g.w[2], exp_g.w[3],
                       exp_g.last, first_texel_index_o, got[0], got[1], got[2],
                       got[3], last_group_o);
          end
        end
      end
      pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // ---- timeout ------------------------------------------------------------
  always @(posedge clk_i) begin
    if (cycle_count > 20000000) begin
      $display("gradient_ramp_texture_builder verification failed");
      $finish;
    end
  end

  task automatic drain_phase();
    while (pending_stops.size() > 0 || expected_groups.size() > 0) @(posedge clk_i);
  endtask

  // ---- sequence -----------------------------------------------------------
  initial begin
    errors = 0; cycle_count = 0; stim_done = 0;
    send_idle_pct = 0; recv_stall_pct = 0;
    held_count = 0;
    push = 0; pop = 0;
    stop_position_i = '0; stop_red_i = '0; stop_green_i = '0;
    stop_blue_i = '0; stop_alpha_i = '0; last_stop_i = 0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, single stop, saturation, unsorted, full store
    begin
      stop_item_t it;
      it = '{17'h00000, 8'hff, 8'h00, 8'hff, 8'hff, 1'b0}; pending_stops.push_back(it);
      it = '{17'h1ffff, 8'h00, 8'hff, 8'h00, 8'h00, 1'b1}; pending_stops.push_back(it);
      it = '{17'h08000, 8'hff, 8'hff, 8'hff, 8'h80, 1'b1}; pending_stops.push_back(it);
      it = '{17'h0c000, 8'h10, 8'hf0, 8'h55, 8'hff, 1'b0}; pending_stops.push_back(it);
      it = '{17'h04000, 8'haa, 8'h01, 8'hfe, 8'h7f, 1'b0}; pending_stops.push_back(it);
      it = '{17'h10000, 8'h00, 8'h00, 8'h00, 8'hff, 1'b1}; pending_stops.push_back(it);
      for (int k = 0; k < 18; k++)
        pending_stops.push_back(make_stop(k * 4000 + 1, k == 17));
    end
    drain_phase();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 46 : (ph == 3) ? 36 : 0;
      recv_stall_pct = (ph == 2) ? 46 : (ph == 3) ? 36 : 0;
      for (int n = 0; n < 30; ) begin
        int sz;
        if ($urandom_range(0, 9) == 0) begin
          pending_stops.push_back(make_stop($urandom_range(0, 131071), $urandom_range(0, 1)));
          n++;
        end else begin
          sz = $urandom_range(1, 8);
          if ($urandom_range(0, 19) == 0) sz = 17;
          queue_gradient(sz);
          n += sz;
        end
      end
      // close any open gradient so every stop is covered by a build
      pending_stops.push_back(make_stop($urandom_range(0, 65536), 1'b1));
      drain_phase();
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0 && expected_groups.size() == 0) begin
      $display("gradient_ramp_texture_builder verification clean");
    end else begin
      $display("gradient_ramp_texture_builder verification failed");
    end
    $finish;
  end

endmodule
